FILE: design/triangle_barycentric_weights_defines.svh
// Assertion macros shared by the triangle barycentric weights design.
`ifndef TRIANGLE_BARYCENTRIC_WEIGHTS_DEFINES_SVH
`define TRIANGLE_BARYCENTRIC_WEIGHTS_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TBW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbw assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define TBW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbw assertion failed");

`endif

FILE: design/tbw_pkg.sv
// Shared constants, types and functions of the triangle barycentric weights design.
package tbw_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int FRAC_BITS    = 16;
  localparam int WEIGHT_WIDTH = 32;
  // Eight arithmetic stages ahead of one divider stage per quotient bit.
  localparam int LANE_STAGES  = 8 + WEIGHT_WIDTH;

  localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
  localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};

  // Result of one vertex lane at the end of its divider.
  typedef struct packed {
    logic [WEIGHT_WIDTH-1:0] mag;
    logic                    ovf;
    logic                    neg;
    logic                    dzero;
  } lane_res_t;

  // Apply sign, saturation and the degenerate override to a lane result.
  function automatic logic [WEIGHT_WIDTH-1:0] final_weight(lane_res_t r, logic degen);
    logic [WEIGHT_WIDTH-1:0] w;
    if (degen) begin
      w = '0;
    end else if (r.ovf) begin
      w = r.neg ? WEIGHT_MIN : WEIGHT_MAX;
    end else if (r.neg) begin
      w = (r.mag[WEIGHT_WIDTH-1] && (|r.mag[WEIGHT_WIDTH-2:0])) ? WEIGHT_MIN
                                                                 : (~r.mag + 1'b1);
    end else begin
      w = r.mag[WEIGHT_WIDTH-1] ? WEIGHT_MAX : r.mag;
    end
    return w;
  endfunction

endpackage

FILE: design/tbw_wide_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
module tbw_wide_mul #(
  parameter int IW = 68
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [IW-1:0]   a,
  input  logic signed [IW-1:0]   b,
  output logic signed [2*IW-1:0] p
);

  localparam int LOW = (IW + 1) / 2;
  localparam int HIW = IW - LOW;
  localparam int PW  = 2 * IW;

  logic signed [2*HIW-1:0]  pp_hh;
  logic signed [HIW+LOW:0]  pp_hl;
  logic signed [HIW+LOW:0]  pp_lh;
  logic        [2*LOW-1:0]  pp_ll;

  // First stage: the four partial products of the signed high halves and the unsigned low halves.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= $signed(a[IW-1:LOW]) * $signed(b[IW-1:LOW]);
      pp_hl <= $signed(a[IW-1:LOW]) * $signed({1'b0, b[LOW-1:0]});
      pp_lh <= $signed({1'b0, a[LOW-1:0]}) * $signed(b[IW-1:LOW]);
      pp_ll <= a[LOW-1:0] * b[LOW-1:0];
    end
  end

  // Second stage: align and add the partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      p <= (PW'(pp_hh) << (2 * LOW)) + (PW'(pp_hl) << LOW) + (PW'(pp_lh) << LOW)
           + PW'(pp_ll);
    end
  end

endmodule

FILE: design/tbw_lane.sv
// Weight pipeline of one vertex: offsets, dot products, ratio terms and divider.
module tbw_lane #(
  parameter int COORD_WIDTH = tbw_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = tbw_pkg::FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [2:0][COORD_WIDTH-1:0]      q,
  input  logic [2:0][COORD_WIDTH-1:0]      vk,
  input  logic [2:0][COORD_WIDTH-1:0]      vb,
  input  logic [2:0][COORD_WIDTH-1:0]      ve,
  output tbw_pkg::lane_res_t               res
);

  localparam int WW   = tbw_pkg::WEIGHT_WIDTH;
  localparam int DW   = COORD_WIDTH + 1;
  localparam int PW   = 2 * DW;
  localparam int DOTW = PW + 2;
  localparam int WP   = 2 * DOTW;
  localparam int NW   = WP + 1;
  localparam int CW   = NW + FRAC_BITS + 34;

  logic signed [DW-1:0]   off [3];
  logic signed [DW-1:0]   hor [3];
  logic signed [DW-1:0]   up  [3];
  logic signed [PW-1:0]   m_hh [3];
  logic signed [PW-1:0]   m_hu [3];
  logic signed [PW-1:0]   m_ou [3];
  logic signed [PW-1:0]   m_oh [3];
  logic signed [PW-1:0]   m_uu [3];
  logic signed [DOTW-1:0] hh, hu, ou, oh, uu;
  logic signed [WP-1:0]   p_ouhh, p_ohhu, p_uuhh, p_huhu;
  logic signed [NW-1:0]   num, den;
  logic        [NW-1:0]   num_mag, den_mag;
  logic        [CW-1:0]   a_r, b_r;
  logic                   neg_r, dz_r;

  logic [CW-1:0] rem_p [0:WW];
  logic [CW-1:0] b_p   [0:WW];
  logic [WW-1:0] q_p   [0:WW];
  logic          ovf_p [0:WW];
  logic          neg_p [0:WW];
  logic          dz_p  [0:WW];

  // Edge vectors and the offset of the query point from the edge base.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        off[i] <= DW'($signed(q[i]))  - DW'($signed(vb[i]));
        hor[i] <= DW'($signed(ve[i])) - DW'($signed(vb[i]));
        up[i]  <= DW'($signed(vk[i])) - DW'($signed(vb[i]));
      end
    end
  end

  // Component products of the five dot products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_hh[i] <= hor[i] * hor[i];
        m_hu[i] <= hor[i] * up[i];
        m_ou[i] <= off[i] * up[i];
        m_oh[i] <= off[i] * hor[i];
        m_uu[i] <= up[i] * up[i];
      end
    end
  end

  // Dot product sums.
  always_ff @(posedge clk) begin
    if (en) begin
      hh <= DOTW'(m_hh[0]) + DOTW'(m_hh[1]) + DOTW'(m_hh[2]);
      hu <= DOTW'(m_hu[0]) + DOTW'(m_hu[1]) + DOTW'(m_hu[2]);
      ou <= DOTW'(m_ou[0]) + DOTW'(m_ou[1]) + DOTW'(m_ou[2]);
      oh <= DOTW'(m_oh[0]) + DOTW'(m_oh[1]) + DOTW'(m_oh[2]);
      uu <= DOTW'(m_uu[0]) + DOTW'(m_uu[1]) + DOTW'(m_uu[2]);
    end
  end

  // Wide products of the dot products, two stages each.
  tbw_wide_mul #(.IW(DOTW)) u_mul_ouhh (.clk(clk), .en(en), .a(ou), .b(hh), .p(p_ouhh));
  tbw_wide_mul #(.IW(DOTW)) u_mul_ohhu (.clk(clk), .en(en), .a(oh), .b(hu), .p(p_ohhu));
  tbw_wide_mul #(.IW(DOTW)) u_mul_uuhh (.clk(clk), .en(en), .a(uu), .b(hh), .p(p_uuhh));
  tbw_wide_mul #(.IW(DOTW)) u_mul_huhu (.clk(clk), .en(en), .a(hu), .b(hu), .p(p_huhu));

  // Numerator and denominator of the weight.
  always_ff @(posedge clk) begin
    if (en) begin
      num <= NW'(p_ouhh) - NW'(p_ohhu);
      den <= NW'(p_uuhh) - NW'(p_huhu);
    end
  end

  assign num_mag = num[NW-1] ? (~num + 1'b1) : num;
  assign den_mag = den[NW-1] ? (~den + 1'b1) : den;

  // Scaled dividend with the rounding half step, and the doubled divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= (CW'(num_mag) << (FRAC_BITS + 1)) + CW'(den_mag);
      b_r   <= CW'(den_mag) << 1;
      neg_r <= num[NW-1] ^ den[NW-1];
      dz_r  <= (den == '0);
    end
  end

  // Overflow check: the quotient does not fit in the weight width.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_p[0] <= a_r;
      b_p[0]   <= b_r;
      q_p[0]   <= '0;
      ovf_p[0] <= (a_r >= (b_r << WW));
      neg_p[0] <= neg_r;
      dz_p[0]  <= dz_r;
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  for (genvar j = 0; j < WW; j++) begin : g_div
    localparam int SH = WW - 1 - j;
    logic [CW-1:0] shb;
    logic          ge;

    assign shb = b_p[j] << SH;
    assign ge  = (rem_p[j] >= shb);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_p[j+1] <= ge ? (rem_p[j] - shb) : rem_p[j];
        b_p[j+1]   <= b_p[j];
        q_p[j+1]   <= {q_p[j][WW-2:0], ge};
        ovf_p[j+1] <= ovf_p[j];
        neg_p[j+1] <= neg_p[j];
        dz_p[j+1]  <= dz_p[j];
      end
    end
  end

  assign res.mag   = q_p[WW];
  assign res.ovf   = ovf_p[WW];
  assign res.neg   = neg_p[WW];
  assign res.dzero = dz_p[WW];

endmodule

FILE: design/triangle_barycentric_weights.sv
// Top level of the triangle barycentric weights pipeline.
// A request passes through the lane stages and then the output register before its result shows.
// Throughput: one request per cycle while the skid register is free; the 32-stage restoring divider and the
// two-stage wide multipliers are fully pipelined, one quotient bit per stage.
// An output register and a skid register let input continue while one result waits in the output register.
// Reset clears the valid bits and the output and skid flags; data is not reset.
module triangle_barycentric_weights #(
  parameter int COORD_WIDTH = tbw_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = tbw_pkg::FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH-1:0]         query_x,
  input  logic signed [COORD_WIDTH-1:0]         query_y,
  input  logic signed [COORD_WIDTH-1:0]         query_z,
  input  logic signed [COORD_WIDTH-1:0]         v0_x,
  input  logic signed [COORD_WIDTH-1:0]         v0_y,
  input  logic signed [COORD_WIDTH-1:0]         v0_z,
  input  logic signed [COORD_WIDTH-1:0]         v1_x,
  input  logic signed [COORD_WIDTH-1:0]         v1_y,
  input  logic signed [COORD_WIDTH-1:0]         v1_z,
  input  logic signed [COORD_WIDTH-1:0]         v2_x,
  input  logic signed [COORD_WIDTH-1:0]         v2_y,
  input  logic signed [COORD_WIDTH-1:0]         v2_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tbw_pkg::WEIGHT_WIDTH-1:0] weight_0,
  output logic signed [tbw_pkg::WEIGHT_WIDTH-1:0] weight_1,
  output logic signed [tbw_pkg::WEIGHT_WIDTH-1:0] weight_2,
  output logic                                  degenerate
);

  `include "triangle_barycentric_weights_defines.svh"

  localparam int LS = tbw_pkg::LANE_STAGES;
  localparam int WW = tbw_pkg::WEIGHT_WIDTH;

  logic [2:0][COORD_WIDTH-1:0]      qv;
  logic [2:0][2:0][COORD_WIDTH-1:0] vtx;
  tbw_pkg::lane_res_t               lres [3];
  logic [LS-1:0]                    vld;
  logic                             en;
  logic                             degen_now;
  logic [WW-1:0]                    w_now [3];
  logic                             skid_valid;
  logic [WW-1:0]                    skid_w [3];
  logic                             skid_degen;
  logic                             load_out_skid, load_out_pipe, load_skid;

  assign qv     = {query_z, query_y, query_x};
  assign vtx[0] = {v0_z, v0_y, v0_x};
  assign vtx[1] = {v1_z, v1_y, v1_x};
  assign vtx[2] = {v2_z, v2_y, v2_x};

  // The whole pipeline advances while the skid register is free.
  assign en       = !skid_valid;
  assign in_ready = en;

  // One lane per vertex; its opposite edge starts at the next vertex.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    tbw_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk),
      .en (en),
      .q  (qv),
      .vk (vtx[k]),
      .vb (vtx[(k + 1) % 3]),
      .ve (vtx[(k + 2) % 3]),
      .res(lres[k])
    );
  end

  // Valid bits travel alongside the lane data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LS-2:0], in_valid};
    end
  end

  // Final weights of the request leaving the lanes.
  assign degen_now = lres[0].dzero | lres[1].dzero | lres[2].dzero;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w_now[k] = tbw_pkg::final_weight(lres[k], degen_now);
    end
  end

  // Output and skid register moves.
  assign load_out_skid = out_valid && out_ready && skid_valid;
  assign load_out_pipe = en && vld[LS-1] && (!out_valid || out_ready);
  assign load_skid     = en && vld[LS-1] && out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load_out_skid || load_out_pipe) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load_out_skid) begin
        skid_valid <= 1'b0;
      end else if (load_skid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_skid) begin
      weight_0   <= skid_w[0];
      weight_1   <= skid_w[1];
      weight_2   <= skid_w[2];
      degenerate <= skid_degen;
    end else if (load_out_pipe) begin
      weight_0   <= w_now[0];
      weight_1   <= w_now[1];
      weight_2   <= w_now[2];
      degenerate <= degen_now;
    end
    if (load_skid) begin
      skid_w     <= w_now;
      skid_degen <= degen_now;
    end
  end

  // Checks on the output buffering and the degenerate override.
  `TBW_ASSERT_IMPL(a_skid_needs_out, skid_valid, out_valid)
  `TBW_ASSERT_NEXT(a_skid_holds, skid_valid && !out_ready, skid_valid)
  `TBW_ASSERT_IMPL(a_degen_zero, out_valid && degenerate,
                   weight_0 == '0 && weight_1 == '0 && weight_2 == '0)

endmodule
